>>> rtl/swgm_pkg.sv
// ----------------------------------------------------------------------------
// swgm_pkg: shared types for the sliding window gcd maximum block
// Command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package swgm_pkg;

  // controller to datapath commands
  typedef struct packed {
    logic store_wr;    // write incoming value into ring
    logic win_start;   // begin a window scan
    logic rd_issue;    // read next ring entry (stepping back)
    logic gcd_load;    // load fresh read value into gcd unit
    logic gcd_step;    // one subtract-shift step of the remainder
    logic best_upd;    // fold window gcd into best
    logic seq_clear;   // clear per-sequence state
  } swgm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic win_ready;   // element count covers the window
    logic rd_done;     // all window entries read
    logic gcd_busy;    // gcd unit still iterating
  } swgm_sts_t;

endpackage
`default_nettype wire

>>> rtl/sliding_window_gcd_max.sv
// ----------------------------------------------------------------------------
// sliding_window_gcd_max: largest gcd over all windows of a value sequence
// Top level: stream ports, configuration register, result register.
// ----------------------------------------------------------------------------
// Each element is written to a ring of MAX_LEN entries; once window_len
// elements are held, the window ending at that element is scanned back
// entry by entry and folded into a gcd by a shared remainder unit that
// yields one quotient bit per cycle. A stalled result adds its wait on the
// item with last. The item with last yields one result (max_gcd, or
// short_input with 0 when fewer than window_len elements came) and the
// block then starts a new sequence. window_len 0 acts as 1.
// No clearing pass is needed.
`default_nettype none
module sliding_window_gcd_max
  import swgm_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [19:0] value
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [19:0] max_gcd
  output logic             out_tuser,  // short_input
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data // window_len
);

  logic [10:0]           win_len_r;
  swgm_cmd_t             cmd;
  swgm_sts_t             sts;
  logic [VALUE_BITS-1:0] best, in_value;
  logic                  short_seq, out_load;
  logic [19:0]           res_r;
  logic                  short_r, out_valid_r;

  // values wider than the field are truncated, narrower zero filled
  assign in_value = VALUE_BITS'({12'd0, in_tdata[19:0]});

  // window length register
  always_ff @(posedge clk) begin
    if (!rst_n) win_len_r <= 11'd1;
    else if (cfg_wr_en) win_len_r <= cfg_wr_data;
  end

  swgm_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tlast,
    .out_load, .out_busy(out_valid_r && !out_tready), .sts, .cmd
  );

  swgm_datapath #(.MAX_LEN(MAX_LEN), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_value, .win_len(win_len_r),
    .best, .short_seq
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
    if (out_load) begin
      res_r   <= short_seq ? 20'd0 : 20'({32'd0, best});
      short_r <= short_seq;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r};
  assign out_tuser  = short_r;

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 24'd0)
    else $error("short result with nonzero value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_tvalid && !out_tready))
    else $error("result overwritten");

endmodule
`default_nettype wire

>>> rtl/swgm_datapath.sv
// ----------------------------------------------------------------------------
// swgm_datapath: ring store, element count, gcd unit and running maximum
// The gcd unit reduces a pair by a restoring remainder, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module swgm_datapath
  import swgm_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire swgm_cmd_t             cmd,
  output swgm_sts_t                  sts,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic [10:0]           win_len,
  output logic      [VALUE_BITS-1:0] best,
  output logic                       short_seq
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int SW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] mem [MAX_LEN];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic [AW-1:0]         wr_pos_r, rd_pos_r;
  logic [CW-1:0]         count_r;
  logic [10:0]           left_r;
  logic [VALUE_BITS-1:0] best_r;
  logic [11:0]           k_eff;

  // gcd state: a_r holds the running gcd; a/b the euclid pair
  logic [VALUE_BITS-1:0] a_r, b_r, rem_r;
  logic [SW-1:0]         bit_r;
  logic                  busy_r, in_div_r;

  assign k_eff = (win_len == 11'd0) ? 12'd1 : {1'b0, win_len};

  // ring write and registered read
  always_ff @(posedge clk) begin
    if (cmd.store_wr) mem[wr_pos_r] <= in_value;
    if (cmd.rd_issue) rd_data_r <= mem[rd_pos_r];
  end

  // positions and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r <= '0;
      count_r  <= '0;
      rd_pos_r <= '0;
      left_r   <= '0;
    end else begin
      if (cmd.seq_clear) begin
        wr_pos_r <= '0;
        count_r  <= '0;
      end else if (cmd.store_wr) begin
        wr_pos_r <= (wr_pos_r == AW'(MAX_LEN - 1)) ? '0 : wr_pos_r + 1'b1;
        if (count_r != CW'(MAX_LEN)) count_r <= count_r + 1'b1;
      end
      if (cmd.win_start) begin
        rd_pos_r <= (wr_pos_r == '0) ? AW'(MAX_LEN - 1) : wr_pos_r - 1'b1;
        left_r   <= k_eff[10:0];
      end else if (cmd.rd_issue) begin
        rd_pos_r <= (rd_pos_r == '0) ? AW'(MAX_LEN - 1) : rd_pos_r - 1'b1;
        left_r   <= left_r - 1'b1;
      end
    end
  end

  assign sts.win_ready = (32'(count_r) >= 32'(k_eff));
  assign sts.rd_done   = (left_r == 11'd0);
  assign sts.gcd_busy  = busy_r;

  // gcd(a,b): a = running gcd, b = new value; repeat a mod b then swap
  logic [VALUE_BITS:0]   trial;
  assign trial = {rem_r, a_r[VALUE_BITS-1]} - {1'b0, b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      in_div_r <= 1'b0;
      bit_r    <= '0;
      a_r      <= '0;
      b_r      <= '0;
      rem_r    <= '0;
    end else if (cmd.win_start) begin
      a_r    <= '0;
      busy_r <= 1'b0;
    end else if (cmd.gcd_load) begin
      // pair (g, v): gcd(g,v) = gcd(v, g mod v) when v != 0
      busy_r   <= 1'b1;
      in_div_r <= 1'b0;
      b_r      <= rd_data_r;
    end else if (cmd.gcd_step && busy_r) begin
      if (!in_div_r) begin
        if (b_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          in_div_r <= 1'b1;
          rem_r    <= '0;
          bit_r    <= SW'(VALUE_BITS);
        end
      end else if (bit_r != '0) begin
        // one remainder bit per cycle, dividend shifts out of a_r
        a_r   <= a_r << 1;
        rem_r <= trial[VALUE_BITS] ? {rem_r[VALUE_BITS-2:0], a_r[VALUE_BITS-1]}
                                   : trial[VALUE_BITS-1:0];
        bit_r <= bit_r - 1'b1;
      end else begin
        // swap: (a,b) <- (b, a mod b)
        a_r      <= b_r;
        b_r      <= rem_r;
        in_div_r <= 1'b0;
      end
    end
  end

  // running maximum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else if (cmd.seq_clear) begin
      best_r <= '0;
    end else if (cmd.best_upd && a_r > best_r) begin
      best_r <= a_r;
    end
  end

  assign best      = best_r;
  assign short_seq = !sts.win_ready;

  property p_no_load_when_busy;
    @(posedge clk) disable iff (!rst_n) busy_r |-> !cmd.gcd_load;
  endproperty
  a_no_load_when_busy: assert property (p_no_load_when_busy)
    else $error("gcd load while unit busy");

  a_best_grows: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cmd.seq_clear) |-> best_r >= $past(best_r))
    else $error("running maximum decreased");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LEN))
    else $error("element count beyond store depth");

endmodule
`default_nettype wire

>>> rtl/swgm_ctrl.sv
// ----------------------------------------------------------------------------
// swgm_ctrl: sequencer for store, window scan, gcd iteration and result
// One item at a time; the result register frees the controller early.
// ----------------------------------------------------------------------------
`default_nettype none
module swgm_ctrl
  import swgm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire logic      in_tlast,
  output logic           out_load,
  input  wire logic      out_busy,
  input  wire swgm_sts_t sts,
  output swgm_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_GCD   = 3'd4;
  localparam logic [2:0] S_BEST  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE) && rst_n;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.store_wr = 1'b1;
          last_nxt     = in_tlast;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.win_ready) begin
          cmd.win_start = 1'b1;
          state_nxt     = S_READ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        if (sts.rd_done) begin
          state_nxt = S_BEST;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.gcd_load = 1'b1;
        state_nxt    = S_GCD;
      end
      S_GCD: begin
        cmd.gcd_step = 1'b1;
        if (!sts.gcd_busy) state_nxt = S_READ;
      end
      S_BEST: begin
        cmd.best_upd = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (!out_busy) begin
          out_load      = 1'b1;
          cmd.seq_clear = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_load_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> state_r == S_DONE && last_r && !out_busy)
    else $error("result loaded outside done state");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_wr |=> state_r == S_CHECK)
    else $error("store write did not lead to window check");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seq_clear |=> state_r == S_IDLE)
    else $error("sequence clear not followed by idle");

endmodule
`default_nettype wire
